[rtl/lsic_pkg.sv]
// Shared types and codes for the LIFO stack with indexed change.
package lsic_pkg;

	localparam int LSIC_DEPTH = 16;

	localparam logic [2:0] FN_PUSH   = 3'd0;
	localparam logic [2:0] FN_POP    = 3'd1;
	localparam logic [2:0] FN_PEEK   = 3'd2;
	localparam logic [2:0] FN_CHANGE = 3'd3;
	localparam logic [2:0] FN_DUMP   = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_BEYOND = 2'd3;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] data_value;
		logic [3:0]         position;
	} lsic_in_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic [1:0]         status;
		logic [4:0]         fill_count;
		logic               last_of_run;
	} lsic_out_t;

	// What every cell of the row does in a cycle
	typedef enum logic [2:0] {
		CO_HOLD  = 3'd0,
		CO_PUSH  = 3'd1,
		CO_POP   = 3'd2,
		CO_WRITE = 3'd3,
		CO_ROT   = 3'd4
	} cell_op_t;

endpackage

[rtl/lsic_cell.sv]
// One word of the stack: index 0 is the top, data moves between neighbours.
module lsic_cell #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  lsic_pkg::cell_op_t   op,
	input  logic [IW-1:0]        sel_idx,
	input  logic signed [31:0]   from_above,
	input  logic signed [31:0]   from_below,
	input  logic signed [31:0]   wrap_value,
	input  logic signed [31:0]   wr_data,
	output logic signed [31:0]   value
);
	import lsic_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic signed [31:0] value_q;
	logic               hit;

	assign hit   = (sel_idx == MY_IDX);
	assign value = value_q;

	always_ff @(posedge clk) begin
		case (op)
			CO_PUSH:  value_q <= from_above;
			CO_POP:   value_q <= from_below;
			CO_WRITE: if (hit) value_q <= wr_data;
			CO_ROT:   value_q <= hit ? wrap_value : from_below;
			default:  value_q <= value_q;
		endcase
	end

endmodule

[rtl/lifo_stack_with_indexed_change_core.sv]
// LIFO stack top level: control, fill count and a row of shifting word cells.
// Push, pop, peek, change and unused codes give one result: the transaction is accepted
// when start is high and busy is low, and its single result is strobed on valid in the
// next cycle. A dump of n stored words keeps busy high while it runs and strobes one
// result per cycle, top word first; the row of cells rotates the top word out each
// cycle, so after the dump the stack holds what it held before. A dump of an empty
// stack gives one result. Results cannot be held off and must be taken when valid is
// high. The stack holds DEPTH words; push shifts the row down, pop shifts it up.
module lifo_stack_with_indexed_change_core #(
	parameter int DEPTH = lsic_pkg::LSIC_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lsic_pkg::lsic_in_t cmd,
	output logic               valid,
	output lsic_pkg::lsic_out_t rsp
);
	import lsic_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int PW = (CW > 4) ? CW : 4;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [CW-1:0]      count_q, left_q, next_count;
	logic               dump_q, valid_q;
	lsic_out_t          rsp_q;
	logic               accept, full, empty, pos_ok;
	logic [CW-1:0]      top_idx;
	cell_op_t           op;
	logic [IW-1:0]      sel_idx;
	logic signed [31:0] cell_val [DEPTH];

	assign accept  = start && !dump_q;
	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign pos_ok  = (PW'(cmd.position) < PW'(count_q));
	assign top_idx = count_q - CW'(1);
	assign busy    = dump_q;
	assign valid   = valid_q;
	assign rsp     = rsp_q;

	always_comb begin
		op         = CO_HOLD;
		sel_idx    = IW'(top_idx);
		next_count = count_q;
		if (dump_q) begin
			op = CO_ROT;
		end else if (accept) begin
			case (cmd.func)
				FN_PUSH: if (!full) begin
					op         = CO_PUSH;
					next_count = count_q + CW'(1);
				end
				FN_POP: if (!empty) begin
					op         = CO_POP;
					next_count = count_q - CW'(1);
				end
				FN_CHANGE: if (pos_ok) begin
					op      = CO_WRITE;
					// position counts from the bottom, cells from the top
					sel_idx = IW'(top_idx - CW'(cmd.position));
				end
				default: op = CO_HOLD;
			endcase
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lsic_cell #(.IW(IW), .IDX(i)) u_cell (
			.clk        (clk),
			.op         (op),
			.sel_idx    (sel_idx),
			.from_above ((i == 0) ? cmd.data_value : cell_val[(i == 0) ? 0 : i - 1]),
			.from_below ((i == DEPTH - 1) ? cell_val[i] : cell_val[(i == DEPTH - 1) ? i : i + 1]),
			.wrap_value (cell_val[0]),
			.wr_data    (cmd.data_value),
			.value      (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dump_q  <= 1'b0;
			left_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			count_q <= next_count;
			valid_q <= 1'b0;
			if (dump_q) begin
				valid_q <= 1'b1;
				left_q  <= left_q - CW'(1);
				if (left_q == CW'(1)) dump_q <= 1'b0;
			end else if (accept) begin
				if (cmd.func == FN_DUMP && !empty) begin
					dump_q <= 1'b1;
					left_q <= count_q;
				end else begin
					valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dump_q) begin
			rsp_q.value_out   <= cell_val[0];
			rsp_q.status      <= ST_OK;
			rsp_q.fill_count  <= 5'(count_q);
			rsp_q.last_of_run <= (left_q == CW'(1));
		end else if (accept) begin
			rsp_q.value_out   <= '0;
			rsp_q.status      <= ST_OK;
			rsp_q.fill_count  <= 5'(next_count);
			rsp_q.last_of_run <= 1'b1;
			case (cmd.func)
				FN_PUSH: if (full) rsp_q.status <= ST_FULL;
				FN_POP, FN_PEEK: begin
					if (empty) rsp_q.status <= ST_EMPTY;
					else rsp_q.value_out <= cell_val[0];
				end
				FN_CHANGE: if (!pos_ok) rsp_q.status <= ST_BEYOND;
				FN_DUMP: if (empty) rsp_q.status <= ST_EMPTY;
				default: rsp_q.status <= ST_OK;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("stack count beyond depth");
	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		dump_q |-> (left_q != '0) && !empty)
		else $error("dump running with nothing left");
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.func != FN_DUMP) |=> valid_q && rsp_q.last_of_run)
		else $error("single-result transaction gave no final result");
	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		(dump_q && left_q == CW'(1)) |=> !dump_q && valid_q && rsp_q.last_of_run)
		else $error("dump did not end on its last word");
	a_dump_count_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		dump_q |=> $stable(count_q))
		else $error("count moved during dump");
`endif

endmodule

[tb/tb_lifo_stack_with_indexed_change_core.sv]
// Self-checking testbench for the LIFO stack with indexed change against a predicted stack.
`timescale 1ns / 1ps

module tb_lifo_stack_with_indexed_change_core;
	import lsic_pkg::*;

	// func codes with no operation behind them
	localparam logic [2:0] FN_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] FN_UNUSED_LAST  = 3'd7;
	localparam int RANDOM_CMDS = 400;

	typedef struct {
		lsic_in_t cmd;
		bit       drain_first;
	} queued_cmd_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	lsic_in_t  cmd = '0;
	logic      valid;
	lsic_out_t rsp;

	queued_cmd_t cmd_queue[$];
	lsic_out_t   rsp_due[$];

	logic signed [31:0] stack_words[LSIC_DEPTH];
	int stack_fill = 0;
	int gen_fill = 0;
	int errors = 0;
	int gap_left = 0;
	int burst_left = 0;
	logic drive_next;
	queued_cmd_t head;
	lsic_out_t want;

	lifo_stack_with_indexed_change_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.valid(valid),
		.rsp(rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Stack behaviour per accepted transaction; queues every result it will cause
	function automatic void predict_stack_op(lsic_in_t c);
		lsic_out_t r;
		r = '0;
		r.last_of_run = 1'b1;
		case (c.func)
		FN_PUSH: begin
			if (stack_fill >= LSIC_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				stack_words[stack_fill] = c.data_value;
				stack_fill++;
			end
		end
		FN_POP: begin
			if (stack_fill == 0) begin
				r.status = ST_EMPTY;
			end else begin
				stack_fill--;
				r.value_out = stack_words[stack_fill];
			end
		end
		FN_PEEK: begin
			if (stack_fill == 0)
				r.status = ST_EMPTY;
			else
				r.value_out = stack_words[stack_fill - 1];
		end
		FN_CHANGE: begin
			if (int'(c.position) >= stack_fill)
				r.status = ST_BEYOND;
			else
				stack_words[c.position] = c.data_value;
		end
		FN_DUMP: begin
			if (stack_fill == 0) begin
				r.status = ST_EMPTY;
			end else begin
				// top first; stack itself is left as it was
				for (int i = stack_fill - 1; i >= 0; i--) begin
					r.value_out = stack_words[i];
					r.status = ST_OK;
					r.fill_count = 5'(stack_fill);
					r.last_of_run = (i == 0);
					rsp_due.push_back(r);
				end
				return;
			end
		end
		default: ;
		endcase
		r.fill_count = 5'(stack_fill);
		rsp_due.push_back(r);
	endfunction

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 7))
		0: return 32'sh8000_0000;
		1: return 32'sh7fff_ffff;
		2: return 32'sd0;
		3: return -32'sd1;
		default: return $urandom;
		endcase
	endfunction

	function automatic void add_cmd(logic [2:0] f, logic signed [31:0] d, logic [3:0] p,
		bit drain);
		queued_cmd_t q;
		q.cmd.func = f;
		q.cmd.data_value = d;
		q.cmd.position = p;
		q.drain_first = drain;
		cmd_queue.push_back(q);
		if (f == FN_PUSH && gen_fill < LSIC_DEPTH)
			gen_fill++;
		else if (f == FN_POP && gen_fill > 0)
			gen_fill--;
	endfunction

	function automatic logic [2:0] pick_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return FN_PUSH;
		if (r < 60) return FN_POP;
		if (r < 70) return FN_PEEK;
		if (r < 85) return FN_CHANGE;
		if (r < 95) return FN_DUMP;
		return 3'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
	endfunction

	// Driver: bursts of back-to-back transactions with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			drive_next = start;
			if (start && !busy) begin
				predict_stack_op(cmd);
				drive_next = 1'b0;
			end
			if (!drive_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_queue.size() != 0 &&
						!(cmd_queue[0].drain_first && rsp_due.size() != 0)) begin
					head = cmd_queue.pop_front();
					cmd <= head.cmd;
					drive_next = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 23);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			start <= drive_next;
		end
	end

	// Monitor: results cannot be held off, so every strobe is checked
	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (rsp_due.size() == 0) begin
				$display("%0t: unexpected result %0d/%0d/%0d/%0b",
					$time, rsp.value_out, rsp.status, rsp.fill_count, rsp.last_of_run);
				errors++;
			end else begin
				want = rsp_due.pop_front();
				if (rsp.value_out !== want.value_out || rsp.status !== want.status ||
						rsp.fill_count !== want.fill_count ||
						rsp.last_of_run !== want.last_of_run) begin
					// value_out/status/fill_count/last_of_run
					$display("%0t: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
						$time, want.value_out, want.status, want.fill_count,
						want.last_of_run, rsp.value_out, rsp.status, rsp.fill_count,
						rsp.last_of_run);
					errors++;
				end
			end
		end
	end

	initial begin
		int seg;
		int n;
		logic [2:0] f;
		logic [3:0] p;

		// directed: empty-stack cases, extremes, change bounds, dump, spare codes
		add_cmd(FN_POP, 32'sd5, 4'd0, 0);
		add_cmd(FN_PEEK, 32'sd0, 4'd15, 0);
		add_cmd(FN_DUMP, -32'sd1, 4'd0, 0);
		add_cmd(FN_CHANGE, 32'sd77, 4'd0, 0);
		add_cmd(FN_PUSH, 32'sh8000_0000, 4'd0, 0);
		add_cmd(FN_PUSH, 32'sh7fff_ffff, 4'd15, 0);
		add_cmd(FN_PUSH, -32'sd1, 4'd0, 0);
		add_cmd(FN_PEEK, 32'sd0, 4'd0, 0);
		add_cmd(FN_CHANGE, 32'sd0, 4'd2, 0);
		add_cmd(FN_CHANGE, 32'sd9, 4'd3, 0);
		add_cmd(FN_CHANGE, 32'sd9, 4'd15, 0);
		add_cmd(FN_CHANGE, 32'sd123, 4'd0, 0);
		add_cmd(FN_DUMP, 32'sd0, 4'd0, 0);
		add_cmd(FN_UNUSED_FIRST, -32'sd1, 4'd15, 0);
		add_cmd(FN_UNUSED_FIRST + 3'd1, 32'sd0, 4'd0, 0);
		add_cmd(FN_UNUSED_LAST, -32'sd1, 4'd15, 0);
		add_cmd(FN_POP, 32'sd0, 4'd0, 0);
		add_cmd(FN_POP, 32'sd0, 4'd0, 0);
		add_cmd(FN_POP, 32'sd0, 4'd0, 0);
		add_cmd(FN_POP, 32'sd0, 4'd0, 0);
		// hold off here until the directed results are all in
		add_cmd(FN_PUSH, rand_word(), 4'($urandom_range(0, 15)), 1);

		n = cmd_queue.size() + RANDOM_CMDS;
		while (cmd_queue.size() < n) begin
			seg = $urandom_range(0, 5);
			if (seg == 0) begin
				// fill past full so overflow is hit
				repeat (LSIC_DEPTH - gen_fill + $urandom_range(1, 3))
					add_cmd(FN_PUSH, rand_word(), 4'($urandom_range(0, 15)), 0);
				add_cmd(FN_DUMP, rand_word(), 4'($urandom_range(0, 15)), 0);
			end else if (seg == 1) begin
				repeat (gen_fill + $urandom_range(1, 2))
					add_cmd(FN_POP, rand_word(), 4'($urandom_range(0, 15)), 0);
			end else begin
				repeat ($urandom_range(8, 30)) begin
					f = pick_func();
					if (f == FN_CHANGE && gen_fill > 0 && $urandom_range(0, 3) != 0)
						p = 4'($urandom_range(0, gen_fill - 1));
					else
						p = 4'($urandom_range(0, 15));
					add_cmd(f, rand_word(), p, $urandom_range(0, 99) == 0);
				end
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (cmd_queue.size() != 0 || start || rsp_due.size() != 0);
		repeat (20) @(posedge clk);

		if (errors == 0 && rsp_due.size() == 0)
			$display("[lifo_stack_with_indexed_change_core] OK");
		else
			$display("[lifo_stack_with_indexed_change_core] ERROR");
		$finish;
	end

	initial begin
		#500000;
		$display("[lifo_stack_with_indexed_change_core] ERROR");
		$finish;
	end

endmodule
